/* hdl/triangle_point_locator_top_macros.svh */
// Assertion macros shared by the locator checker.
`ifndef TRIANGLE_POINT_LOCATOR_TOP_MACROS_SVH
`define TRIANGLE_POINT_LOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TPL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define TPL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/tpl_pkg.sv */
// Types, constants and codes for the triangle point locator.
package tpl_pkg;
   localparam int COORD_BITS = 24;
   localparam int DEF_MAX_TRIANGLES = 1024;
   localparam int DEF_MAX_VERTICES = 1024;
   localparam int IDX_BITS = 10;
   localparam int CNT_BITS = 11;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int ACC_BITS = PROD_BITS + 3;

   typedef enum logic [1:0] {
      CMD_VERTEX = 2'd0,
      CMD_TRIANGLE = 2'd1,
      CMD_LOCATE = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [IDX_BITS-1:0] slot;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic [IDX_BITS-1:0] corner_first;
      logic [IDX_BITS-1:0] corner_second;
      logic [IDX_BITS-1:0] corner_third;
   } req_type;

   typedef struct packed {
      logic found;
      logic [IDX_BITS-1:0] triangle;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic hit;
   } test_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRI_RD,
      ST_V0_RD,
      ST_V1_RD,
      ST_V2_RD,
      ST_V2_CAP,
      ST_TEST_GO,
      ST_TEST_WAIT,
      ST_FINISH
   } state_type;
endpackage

/* hdl/triangle_point_locator_top.sv */
// Triangle point locator: tables, search sequencer and result register.
//
// req channel (valid/ready): one word per command. Vertex and triangle
// writes give no result. A locate word starts a search over triangle
// entries 0 .. active_triangles-1 (saturated to MAX_TRIANGLES); req_ready
// stays low until the search ends.
// Each triangle takes one triangle table read, three vertex reads on the
// single vertex table port, a capture and a start step, then the test
// unit, which shares one multiplier over six products. A query outside
// the triangle's bounding box skips the products.
// rsp channel: one word per locate, held in an output register until
// taken; a stalled receiver only holds the next search at its end.
// csr_: active_triangles, written whenever csr_write_enable is high.
// Reset (synchronous) clears control and active_triangles; table contents
// are undefined until written.
module triangle_point_locator_top import tpl_pkg::*; #(
   parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [CNT_BITS-1:0] csr_write_data
);
   localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int TCW = $clog2(MAX_TRIANGLES + 1);

   logic [3*IDX_BITS-1:0] tri_mem [MAX_TRIANGLES];
   logic [2*COORD_BITS-1:0] vtx_mem [MAX_VERTICES];

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] active_ff;
   logic [TCW-1:0] k_ff, k_in, n_ff;
   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;
   logic signed [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [3*IDX_BITS-1:0] tri_q_ff;
   logic [2*COORD_BITS-1:0] vtx_q_ff, vtx_v;
   logic oor_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic found_ff, found_in;

   logic accept, test_start, load_rsp;
   logic [IDX_BITS-1:0] corner;
   logic [31:0] corner_w, slot_w, k_w, active_w;
   logic [TCW-1:0] n_new;
   test_status_type test_st;

   assign accept = req_valid && req_ready;
   assign slot_w = 32'(req_data.slot);
   assign k_w = 32'(k_ff);
   assign active_w = 32'(active_ff);
   assign n_new = (active_w > 32'(MAX_TRIANGLES)) ? TCW'(MAX_TRIANGLES) : TCW'(active_ff);
   assign corner_w = 32'(corner);
   assign vtx_v = oor_ff ? '0 : vtx_q_ff;

   tpl_test u_test (
      .clock(clock), .reset(reset), .start(test_start),
      .x0(x0_ff), .y0(y0_ff), .x1(x1_ff), .y1(y1_ff), .x2(x2_ff), .y2(y2_ff),
      .qx(qx_ff), .qy(qy_ff), .status(test_st)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      found_in = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.command == CMD_LOCATE) begin
               k_in = '0;
               found_in = 1'b0;
               state_in = (n_new == '0) ? ST_FINISH : ST_TRI_RD;
            end
         end
         ST_TRI_RD: state_in = ST_V0_RD;
         ST_V0_RD: state_in = ST_V1_RD;
         ST_V1_RD: state_in = ST_V2_RD;
         ST_V2_RD: state_in = ST_V2_CAP;
         ST_V2_CAP: state_in = ST_TEST_GO;
         ST_TEST_GO: state_in = ST_TEST_WAIT;
         ST_TEST_WAIT: begin
            if (test_st.done) begin
               if (test_st.hit) begin
                  found_in = 1'b1;
                  state_in = ST_FINISH;
               end else if (k_ff + TCW'(1) < n_ff) begin
                  k_in = k_ff + TCW'(1);
                  state_in = ST_TRI_RD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      test_start = (state_ff == ST_TEST_GO);
      load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
      unique case (state_ff)
         ST_V1_RD: corner = tri_q_ff[2*IDX_BITS-1:IDX_BITS];
         ST_V2_RD: corner = tri_q_ff[3*IDX_BITS-1:2*IDX_BITS];
         default: corner = tri_q_ff[IDX_BITS-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         found_ff <= found_in;
         if (csr_write_enable) active_ff <= csr_write_data;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.command == CMD_LOCATE) begin
         qx_ff <= req_data.coord_x;
         qy_ff <= req_data.coord_y;
         n_ff <= n_new;
      end
      if (load_rsp) begin
         rsp_ff.found <= found_ff;
         rsp_ff.triangle <= found_ff ? k_w[IDX_BITS-1:0] : '0;
      end
   end

   // tables
   always_ff @(posedge clock) begin
      if (accept && req_data.command == CMD_TRIANGLE && slot_w < 32'(MAX_TRIANGLES))
         tri_mem[slot_w[TAW-1:0]] <= {req_data.corner_third, req_data.corner_second,
                                     req_data.corner_first};
      if (state_ff == ST_TRI_RD) tri_q_ff <= tri_mem[k_w[TAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.command == CMD_VERTEX && slot_w < 32'(MAX_VERTICES))
         vtx_mem[slot_w[VAW-1:0]] <= {req_data.coord_y, req_data.coord_x};
      vtx_q_ff <= vtx_mem[corner_w[VAW-1:0]];
      oor_ff <= corner_w >= 32'(MAX_VERTICES);
      unique case (state_ff)
         ST_V1_RD: begin
            x0_ff <= vtx_v[COORD_BITS-1:0];
            y0_ff <= vtx_v[2*COORD_BITS-1:COORD_BITS];
         end
         ST_V2_RD: begin
            x1_ff <= vtx_v[COORD_BITS-1:0];
            y1_ff <= vtx_v[2*COORD_BITS-1:COORD_BITS];
         end
         ST_V2_CAP: begin
            x2_ff <= vtx_v[COORD_BITS-1:0];
            y2_ff <= vtx_v[2*COORD_BITS-1:COORD_BITS];
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

/* hdl/tpl_test.sv */
// Containment test for one triangle: bounding box, then exact barycentric
// test on one shared multiplier over six products.
module tpl_test import tpl_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2, qx, qy,
   output test_status_type status
);
   logic busy_ff, busy_in;
   logic [2:0] cnt_ff, cnt_in;
   logic fail_ff, fail_in;
   logic signed [DIFF_BITS-1:0] a11_ff, a12_ff, a21_ff, a22_ff, dx_ff, dy_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [ACC_BITS-1:0] det_ff, n1_ff, n2_ff, det_in, n1_in, n2_in;
   logic signed [DIFF_BITS-1:0] op_a, op_b;
   logic signed [ACC_BITS-1:0] prod_ext, det_m, n1_m, n2_m, sum_m;
   logic box_fail;
   logic signed [COORD_BITS-1:0] minx, maxx, miny, maxy;

   function automatic logic signed [DIFF_BITS-1:0] sub(
      input logic signed [COORD_BITS-1:0] a, input logic signed [COORD_BITS-1:0] b);
      sub = DIFF_BITS'(a) - DIFF_BITS'(b);
   endfunction

   always_comb begin
      minx = (x0 < x1) ? x0 : x1;
      minx = (minx < x2) ? minx : x2;
      maxx = (x0 > x1) ? x0 : x1;
      maxx = (maxx > x2) ? maxx : x2;
      miny = (y0 < y1) ? y0 : y1;
      miny = (miny < y2) ? miny : y2;
      maxy = (y0 > y1) ? y0 : y1;
      maxy = (maxy > y2) ? maxy : y2;
      box_fail = (qx < minx) || (qx > maxx) || (qy < miny) || (qy > maxy);
   end

   always_comb begin
      unique case (cnt_ff)
         3'd0: begin op_a = a11_ff; op_b = a22_ff; end
         3'd1: begin op_a = a21_ff; op_b = a12_ff; end
         3'd2: begin op_a = a22_ff; op_b = dx_ff; end
         3'd3: begin op_a = a21_ff; op_b = dy_ff; end
         3'd4: begin op_a = a11_ff; op_b = dy_ff; end
         default: begin op_a = a12_ff; op_b = dx_ff; end
      endcase
   end

   assign prod_ext = ACC_BITS'(prod_ff);

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      fail_in = fail_ff;
      det_in = det_ff;
      n1_in = n1_ff;
      n2_in = n2_ff;
      if (start) begin
         busy_in = 1'b1;
         fail_in = box_fail;
         cnt_in = box_fail ? 3'd7 : 3'd0;
         det_in = '0;
         n1_in = '0;
         n2_in = '0;
      end else if (busy_ff) begin
         // product of the previous step lands in its sum
         unique case (cnt_ff)
            3'd1: det_in = det_ff + prod_ext;
            3'd2: det_in = det_ff - prod_ext;
            3'd3: n1_in = n1_ff + prod_ext;
            3'd4: n1_in = n1_ff - prod_ext;
            3'd5: n2_in = n2_ff + prod_ext;
            3'd6: n2_in = n2_ff - prod_ext;
            default: ;
         endcase
         if (cnt_ff == 3'd7) busy_in = 1'b0;
         else cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      fail_ff <= fail_in;
      det_ff <= det_in;
      n1_ff <= n1_in;
      n2_ff <= n2_in;
      prod_ff <= op_a * op_b;
      if (start) begin
         a11_ff <= sub(x1, x0);
         a12_ff <= sub(y1, y0);
         a21_ff <= sub(x2, x0);
         a22_ff <= sub(y2, y0);
         dx_ff <= sub(qx, x0);
         dy_ff <= sub(qy, y0);
      end
   end

   // match signs to det, then n1 >= 0, n2 >= 0, n1 + n2 <= det
   always_comb begin
      det_m = det_ff[ACC_BITS-1] ? -det_ff : det_ff;
      n1_m = det_ff[ACC_BITS-1] ? -n1_ff : n1_ff;
      n2_m = det_ff[ACC_BITS-1] ? -n2_ff : n2_ff;
      sum_m = n1_m + n2_m;
      status.done = busy_ff && (cnt_ff == 3'd7);
      status.hit = !fail_ff && (det_ff != '0) && !n1_m[ACC_BITS-1] &&
                   !n2_m[ACC_BITS-1] && (sum_m <= det_m);
   end
endmodule

/* hdl/tpl_checker.sv */
// Port-level checks for the triangle point locator, bound to the top level.
`include "triangle_point_locator_top_macros.svh"

module tpl_checker import tpl_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input req_type req_data,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_data
);
   `TPL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `TPL_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))
   `TPL_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_data.found, rsp_data.triangle == '0)
   `TPL_ASSERT_NEXT(a_locate_busy, req_valid && req_ready && req_data.command == CMD_LOCATE,
      !req_ready)
endmodule

bind triangle_point_locator_top tpl_checker u_tpl_checker (.*);

/* verif/tb_triangle_point_locator_top.sv */
// Testbench for the triangle point locator: random and directed commands, scoreboard check.
`timescale 1ns / 1ps

class locate_scoreboard;
   longint vx[1024];
   longint vy[1024];
   logic [29:0] corners[1024];
   int unsigned active;
   tpl_pkg::rsp_type answers[$];
   int mismatches;
   int checked;

   function int pending();
      return answers.size();
   endfunction

   function bit holds_point(int t, longint qx, longint qy);
      longint x0, y0, x1, y1, x2, y2;
      longint a11, a12, a21, a22, dx, dy, det, n1, n2;
      x0 = vx[corners[t][9:0]];   y0 = vy[corners[t][9:0]];
      x1 = vx[corners[t][19:10]]; y1 = vy[corners[t][19:10]];
      x2 = vx[corners[t][29:20]]; y2 = vy[corners[t][29:20]];
      if (qx < x0 && qx < x1 && qx < x2) return 0;
      if (qx > x0 && qx > x1 && qx > x2) return 0;
      if (qy < y0 && qy < y1 && qy < y2) return 0;
      if (qy > y0 && qy > y1 && qy > y2) return 0;
      a11 = x1 - x0; a12 = y1 - y0;
      a21 = x2 - x0; a22 = y2 - y0;
      dx = qx - x0;  dy = qy - y0;
      det = a11 * a22 - a21 * a12;
      if (det == 0) return 0;
      n1 = a22 * dx - a21 * dy;
      n2 = a11 * dy - a12 * dx;
      if (det < 0) begin
         det = -det; n1 = -n1; n2 = -n2;
      end
      return n1 >= 0 && n2 >= 0 && n1 + n2 <= det;
   endfunction

   function void note_word(tpl_pkg::req_type w);
      tpl_pkg::rsp_type r;
      int unsigned n;
      case (tpl_pkg::cmd_type'(w.command))
         tpl_pkg::CMD_VERTEX: begin
            vx[w.slot] = longint'(w.coord_x);
            vy[w.slot] = longint'(w.coord_y);
         end
         tpl_pkg::CMD_TRIANGLE: corners[w.slot] = {w.corner_third, w.corner_second, w.corner_first};
         tpl_pkg::CMD_LOCATE: begin
            r = '0;
            n = active > 1024 ? 1024 : active;
            for (int k = 0; k < n; k++) begin
               if (holds_point(k, longint'(w.coord_x), longint'(w.coord_y))) begin
                  r.found = 1'b1;
                  r.triangle = tpl_pkg::IDX_BITS'(k);
                  break;
               end
            end
            answers.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function void check_word(tpl_pkg::rsp_type got);
      tpl_pkg::rsp_type exp;
      checked++;
      if (answers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result word %p", got);
         return;
      end
      exp = answers.pop_front();
      if (got.found !== exp.found || got.triangle !== exp.triangle) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result mismatch: expected found=%0d tri=%0d, got found=%0d tri=%0d",
                     exp.found, exp.triangle, got.found, got.triangle);
      end
   endfunction
endclass

module tb_triangle_point_locator_top;
   import tpl_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [CNT_BITS-1:0] csr_write_data = '0;

   locate_scoreboard board = new();
   int idle_pct;
   int stall_pct;
   int tri_ok;
   int vlist[$];
   int unsigned cycles;
   int locates;

   triangle_point_locator_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("timeout");
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_word(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_word(rsp_data);
   end

   task send_word(req_type w);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      if (w.command == CMD_VERTEX) vlist.push_back(int'(w.slot));
      if (w.command == CMD_LOCATE) locates++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // only between phases, with nothing in flight
   task set_active(int unsigned v);
      req_valid <= 1'b0;
      // let the last accepted word reach the scoreboard first
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= CNT_BITS'(v);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.active = v;
   endtask

   function req_type word_of(cmd_type c, int slot, int x, int y, int a, int b, int d);
      req_type w;
      w = req_type'({$urandom, $urandom, $urandom});
      w.command = c;
      w.slot = IDX_BITS'(slot);
      w.coord_x = COORD_BITS'(x);
      w.coord_y = COORD_BITS'(y);
      w.corner_first = IDX_BITS'(a);
      w.corner_second = IDX_BITS'(b);
      w.corner_third = IDX_BITS'(d);
      return w;
   endfunction

   function int rand_coord();
      int r;
      r = $urandom_range(99);
      if (r < 70) return int'($urandom_range(4000)) - 2000;
      if (r < 95) return int'($urandom_range(2097152)) - 1048576;
      return $urandom;
   endfunction

   function req_type random_word();
      req_type w;
      int r, t, slot;
      longint cx, cy;
      w = req_type'({$urandom, $urandom, $urandom});
      r = $urandom_range(99);
      if (r < 25) begin
         w.command = CMD_VERTEX;
         w.coord_x = COORD_BITS'(rand_coord());
         w.coord_y = COORD_BITS'(rand_coord());
      end else if (r < 45) begin
         slot = $urandom_range(tri_ok < 31 ? tri_ok : 31);
         w.command = CMD_TRIANGLE;
         w.slot = IDX_BITS'(slot);
         w.corner_first = IDX_BITS'(vlist[$urandom_range(vlist.size() - 1)]);
         w.corner_second = IDX_BITS'(vlist[$urandom_range(vlist.size() - 1)]);
         w.corner_third = IDX_BITS'(vlist[$urandom_range(vlist.size() - 1)]);
         if (slot == tri_ok) tri_ok++;
      end else if (r < 97) begin
         w.command = CMD_LOCATE;
         if (board.active > 0 && $urandom_range(1)) begin
            // aim near the middle of a searched triangle to get hits
            t = $urandom_range(board.active - 1);
            cx = (board.vx[board.corners[t][9:0]] + board.vx[board.corners[t][19:10]]
                  + board.vx[board.corners[t][29:20]]) / 3;
            cy = (board.vy[board.corners[t][9:0]] + board.vy[board.corners[t][19:10]]
                  + board.vy[board.corners[t][29:20]]) / 3;
            w.coord_x = COORD_BITS'(cx + longint'($urandom_range(40)) - 20);
            w.coord_y = COORD_BITS'(cy + longint'($urandom_range(40)) - 20);
         end else begin
            w.coord_x = COORD_BITS'(rand_coord());
            w.coord_y = COORD_BITS'(rand_coord());
         end
      end else begin
         w.command = CMD_NONE;
      end
      return w;
   endfunction

   initial begin
      int lim;
      idle_pct = 0;
      stall_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, degenerate entry, ignored command
      set_active(0);
      send_word(word_of(CMD_LOCATE, 0, 0, 0, 0, 0, 0));
      send_word(word_of(CMD_VERTEX, 0, -8388608, -8388608, 0, 0, 0));
      send_word(word_of(CMD_VERTEX, 1, 8388607, -8388608, 0, 0, 0));
      send_word(word_of(CMD_VERTEX, 2, -8388608, 8388607, 0, 0, 0));
      send_word(word_of(CMD_VERTEX, 3, 8388607, 8388607, 0, 0, 0));
      send_word(word_of(CMD_VERTEX, 4, 0, 0, 0, 0, 0));
      send_word(word_of(CMD_VERTEX, 1023, 100, -100, 0, 0, 0));
      send_word(word_of(CMD_TRIANGLE, 0, 0, 0, 4, 4, 4));
      send_word(word_of(CMD_TRIANGLE, 1, 0, 0, 3, 2, 1));
      send_word(word_of(CMD_TRIANGLE, 2, 0, 0, 0, 1, 2));
      send_word(word_of(CMD_TRIANGLE, 3, 0, 0, 4, 1023, 1));
      send_word(word_of(CMD_NONE, 5, 0, 0, 0, 0, 0));
      tri_ok = 4;
      set_active(4);
      send_word(word_of(CMD_LOCATE, 0, -8388608, -8388608, 0, 0, 0));
      send_word(word_of(CMD_LOCATE, 0, 8388607, 8388607, 0, 0, 0));
      send_word(word_of(CMD_LOCATE, 0, 0, 0, 0, 0, 0));
      send_word(word_of(CMD_LOCATE, 0, 50, -50, 0, 0, 0));
      send_word(word_of(CMD_LOCATE, 0, 8388607, -8388608, 0, 0, 0));
      send_word(word_of(CMD_LOCATE, 0, -8388608, 8388607, 0, 0, 0));
      send_word(word_of(CMD_LOCATE, 0, 1, -1, 0, 0, 0));

      // random phases over the idling mixes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         lim = tri_ok < 16 ? tri_ok : 16;
         set_active(ph == 7 ? lim : $urandom_range(1, lim));
         for (int i = 0; i < 70; i++) send_word(random_word());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d locate queries, %0d results checked, active from 0 up to 16",
               locates, board.checked);
      if (board.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
